// File: sv/swrms_pkg.sv
// Shared definitions for the sliding-window RMS level meter.
// Holds fixed output sizes, the divider radix and the controller command struct.
// No dependencies; used by swrms_ctrl, swrms_dp and sliding_window_rms_top.
package swrms_pkg;

	// The result is 24 bits wide and saturates at all ones.
	localparam int OUT_W = 24;
	localparam logic [OUT_W-1:0] OUT_MAX = 24'hFFFFFF;

	// The mean square is scaled by 2^16 so that the root carries 8 fraction bits.
	localparam int FRAC_BITS = 16;

	// Quotient bits that the divider retires in each cycle.
	localparam int DIV_STEP = 4;

	// Commands from the controller to the datapath, at most one per cycle.
	typedef struct packed {
		logic take;      // capture the incoming sample
		logic rd;        // read the oldest entry, write the new sample, square the new sample
		logic sq;        // square the entry that leaves the window
		logic sum;       // update the running sum and the ring index
		logic div_ld;    // load the divider with the scaled sum
		logic div_step;  // one divider step
		logic root_ld;   // load the root unit with the quotient
		logic root_step; // one root bit
		logic out_ld;    // move the saturated root to the output register
	} cmd_t;

endpackage

// File: sv/sliding_window_rms_top.sv
// Top level of the sliding-window RMS level meter.
// Instantiates swrms_ctrl and swrms_dp; depends on swrms_pkg.
//
// Each request carries one signed sample; each response carries the RMS of the
// last WINDOW samples as floor(sqrt(sum_of_squares * 65536 / WINDOW)), unsigned
// with 8 fraction bits, saturating at 24 bits. Slots not yet written since reset
// count as zero, so the level ramps up over the first WINDOW requests; no
// clearing pass is needed after reset. A request passes through the read, square,
// sum, divider-load, divide, root-load, root and done states. The bit-serial
// square root yields one result bit per cycle, and the divider by WINDOW four
// quotient bits per cycle. The output register lets the next request be taken
// while the previous response waits.
module sliding_window_rms_top #(
	parameter int WINDOW      = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_tdata,  // [SAMPLE_BITS-1:0] sample
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata   // [23:0] rms_level
);

	localparam int SUMW        = 2 * SAMPLE_BITS - 2 + $clog2(WINDOW + 1);
	localparam int DIVW        = SUMW + swrms_pkg::FRAC_BITS;
	localparam int DIV_CYCLES  = (DIVW + swrms_pkg::DIV_STEP - 1) / swrms_pkg::DIV_STEP;
	localparam int SCW         = 2 * SAMPLE_BITS - 1 + swrms_pkg::FRAC_BITS;
	localparam int ROOT_CYCLES = (SCW + (SCW % 2)) / 2;

	swrms_pkg::cmd_t cmd;

	// Sequencer and handshakes.
	swrms_ctrl #(
		.DIV_CYCLES  (DIV_CYCLES),
		.ROOT_CYCLES (ROOT_CYCLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// Ring, running sum, divider and root.
	swrms_dp #(
		.WINDOW      (WINDOW),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sample    (s_tdata[SAMPLE_BITS-1:0]),
		.rms_level (m_tdata)
	);

endmodule

// File: sv/swrms_ctrl.sv
// Controller for the sliding-window RMS level meter.
// Sequences one request through the datapath and owns the stream handshakes.
// Depends on swrms_pkg.
module swrms_ctrl #(
	parameter int DIV_CYCLES  = 15,
	parameter int ROOT_CYCLES = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output swrms_pkg::cmd_t  cmd
);

	localparam int CNT_MAX = (DIV_CYCLES > ROOT_CYCLES) ? DIV_CYCLES : ROOT_CYCLES;
	localparam int CNTW    = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_SQ   = 4'd2;
	localparam logic [3:0] ST_SUM  = 4'd3;
	localparam logic [3:0] ST_DLD  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_SLD  = 4'd6;
	localparam logic [3:0] ST_ROOT = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]      state_q;
	logic [CNTW-1:0] cnt_q;
	logic            out_valid_q;

	// A new request is taken only while no request is in the datapath.
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	// Command decode from the current state.
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.take      = s_tvalid;
			ST_RD:   cmd.rd        = 1'b1;
			ST_SQ:   cmd.sq        = 1'b1;
			ST_SUM:  cmd.sum       = 1'b1;
			ST_DLD:  cmd.div_ld    = 1'b1;
			ST_DIV:  cmd.div_step  = 1'b1;
			ST_SLD:  cmd.root_ld   = 1'b1;
			ST_ROOT: cmd.root_step = 1'b1;
			ST_DONE: cmd.out_ld    = !out_valid_q || m_tready;
			default: cmd = '0;
		endcase
	end

	// State sequence and iteration counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_RD;
				end
				ST_RD:   state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_SUM;
				ST_SUM:  state_q <= ST_DLD;
				ST_DLD: begin
					cnt_q   <= CNTW'(DIV_CYCLES - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SLD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_SLD: begin
					cnt_q   <= CNTW'(ROOT_CYCLES - 1);
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || m_tready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output valid: set when a result is loaded, cleared when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command in a cycle");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_RD))
		else $error("accepted request did not start the read");

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_SLD))
		else $error("divider did not hand over to the root unit");

	a_root_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> (cnt_q <= CNTW'(ROOT_CYCLES - 1)))
		else $error("root counter out of range");

	a_out_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |=> m_tvalid)
		else $error("loaded result not presented");
`endif

endmodule

// File: sv/swrms_dp.sv
// Datapath for the sliding-window RMS level meter: sample ring, running sum
// of squares, radix-16 divider by the window length and bit-serial square root.
// Depends on swrms_pkg; driven by commands from swrms_ctrl.
module swrms_dp #(
	parameter int WINDOW      = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swrms_pkg::cmd_t               cmd,
	input  logic [SAMPLE_BITS-1:0]        sample,
	output logic [swrms_pkg::OUT_W-1:0]   rms_level
);

	localparam int SB    = SAMPLE_BITS;
	localparam int IDXW  = $clog2(WINDOW);
	localparam int SQW   = 2 * SB - 1;
	localparam int SUMW  = 2 * SB - 2 + $clog2(WINDOW + 1);
	localparam int RMW   = $clog2(WINDOW) + 1;
	localparam int DSTEP = swrms_pkg::DIV_STEP;
	localparam int DIVW  = SUMW + swrms_pkg::FRAC_BITS;
	localparam int DIVP  = ((DIVW + DSTEP - 1) / DSTEP) * DSTEP;
	localparam int SCW   = 2 * SB - 1 + swrms_pkg::FRAC_BITS;
	localparam int SQP   = SCW + (SCW % 2);
	localparam int RW    = SQP / 2;
	localparam int OW    = swrms_pkg::OUT_W;

	logic [SB-1:0]   mem [WINDOW];
	logic [SB-1:0]   sample_q;
	logic [SB-1:0]   rd_q;
	logic [IDXW-1:0] idx_q;
	logic            wrapped_q;
	logic [SQW-1:0]  sq_new_q;
	logic [SQW-1:0]  sq_old_q;
	logic [SUMW-1:0] sum_q;
	logic [RMW-1:0]  rem_q;
	logic [DIVP-1:0] dq_q;
	logic [SQP-1:0]  xq_q;
	logic [RW:0]     rq_q;
	logic [RW-1:0]   root_q;
	logic [OW-1:0]   rms_q;

	logic [SB-1:0]     mul_src;
	logic [SB-1:0]     mag;
	logic [2*SB-1:0]   prod;
	logic [RMW-1:0]    rem_t;
	logic [RMW-1:0]    rem_sh;
	logic [DIVP-1:0]   dq_t;
	logic [RW+1:0]     rn;
	logic [RW+1:0]     trial;
	logic [RW+1:0]     diff;
	logic              ge;
	logic [RW+OW-1:0]  root_wide;

	// Ring: the entry at the write index is read before it is overwritten.
	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			rd_q       <= mem[idx_q];
			mem[idx_q] <= sample_q;
		end
	end

	// One squarer shared by the new sample and the leaving entry.
	always_comb begin
		mul_src = cmd.rd ? sample_q : rd_q;
		mag     = mul_src[SB-1] ? SB'(-mul_src) : mul_src;
		prod    = (2*SB)'(mag) * (2*SB)'(mag);
	end

	// Four restoring division steps by the window length per cycle.
	always_comb begin
		rem_t  = rem_q;
		dq_t   = dq_q;
		rem_sh = '0;
		for (int k = 0; k < DSTEP; k++) begin
			rem_sh = {rem_t[RMW-2:0], dq_t[DIVP-1]};
			dq_t   = {dq_t[DIVP-2:0], 1'b0};
			if (rem_sh >= RMW'(WINDOW)) begin
				rem_t   = rem_sh - RMW'(WINDOW);
				dq_t[0] = 1'b1;
			end else begin
				rem_t = rem_sh;
			end
		end
	end

	// One square-root digit: bring down two bits, try root*4+1.
	always_comb begin
		rn    = {rq_q[RW-1:0], xq_q[SQP-1 -: 2]};
		trial = {root_q, 2'b01};
		ge    = (rn >= trial);
		diff  = rn - trial;
	end

	// Saturate the root to the output width.
	assign root_wide = (RW+OW)'(root_q);

	// Ring index, fill flag and running sum carry the reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else if (cmd.sum) begin
			sum_q <= sum_q - SUMW'(sq_old_q) + SUMW'(sq_new_q);
			if (idx_q == IDXW'(WINDOW - 1)) begin
				idx_q     <= '0;
				wrapped_q <= 1'b1;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// Working registers of the squarer, divider, root unit and output.
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			sample_q <= sample;
		end
		if (cmd.rd) begin
			sq_new_q <= prod[SQW-1:0];
		end
		// An entry not yet written since reset counts as zero.
		if (cmd.sq) begin
			sq_old_q <= wrapped_q ? prod[SQW-1:0] : '0;
		end
		if (cmd.div_ld) begin
			rem_q <= '0;
			dq_q  <= DIVP'({sum_q, {swrms_pkg::FRAC_BITS{1'b0}}});
		end else if (cmd.div_step) begin
			rem_q <= rem_t;
			dq_q  <= dq_t;
		end
		if (cmd.root_ld) begin
			xq_q   <= SQP'(dq_q[SCW-1:0]);
			rq_q   <= '0;
			root_q <= '0;
		end else if (cmd.root_step) begin
			xq_q   <= {xq_q[SQP-3:0], 2'b00};
			rq_q   <= ge ? diff[RW:0] : rn[RW:0];
			root_q <= {root_q[RW-2:0], ge};
		end
		if (cmd.out_ld) begin
			rms_q <= (root_wide > (RW+OW)'(swrms_pkg::OUT_MAX)) ?
				swrms_pkg::OUT_MAX : root_wide[OW-1:0];
		end
	end

	assign rms_level = rms_q;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the sliding-window RMS level meter.
// Sends sample requests, predicts every RMS level from its own ring and sum of squares, and
// compares each response; depends on swrms_pkg and sliding_window_rms_top.
module testbench;

	localparam int WINDOW       = 1024;
	localparam int SAMPLE_BITS  = 16;
	localparam int TDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int RESET_CYCLES = 10;
	localparam int DRAIN_CYCLES = 200;
	localparam int STALL_LIMIT  = 5000;
	localparam int HOLD_CYCLES  = 600;
	localparam int RANDOM_ITEMS = 150;
	localparam int FILL_ITEMS   = WINDOW + 16;
	localparam int REPORT_LIMIT = 10;
	localparam int DIRECTED_ROWS = 19;

	localparam logic [SAMPLE_BITS-1:0] MOST_NEGATIVE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [SAMPLE_BITS-1:0] MOST_POSITIVE = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [swrms_pkg::OUT_W-1:0] FULL_SCALE_LEVEL = 24'd8388608;

	// One directed request: the sample, and a typed level where it is obvious.
	typedef struct packed {
		logic [SAMPLE_BITS-1:0]       smp;
		logic                         typed;
		logic [swrms_pkg::OUT_W-1:0]  level;
	} stim_row_t;

	// The first two rows start from the cleared ring: a zero sample gives zero, and a
	// full-scale negative sample alone in the window gives sqrt(2^30 * 64) = 2^18.
	stim_row_t stim_rows [DIRECTED_ROWS] = '{
		{16'h0000, 1'b1, 24'd0},
		{16'h8000, 1'b1, 24'd262144},
		{16'h7FFF, 1'b0, 24'd0},
		{16'h0001, 1'b0, 24'd0},
		{16'hFFFF, 1'b0, 24'd0},
		{16'h0000, 1'b0, 24'd0},
		{16'h5555, 1'b0, 24'd0},
		{16'hAAAA, 1'b0, 24'd0},
		{16'h00FF, 1'b0, 24'd0},
		{16'hFF00, 1'b0, 24'd0},
		{16'h0F0F, 1'b0, 24'd0},
		{16'hF0F0, 1'b0, 24'd0},
		{16'h8001, 1'b0, 24'd0},
		{16'h7FFE, 1'b0, 24'd0},
		{16'h0002, 1'b0, 24'd0},
		{16'hFFFE, 1'b0, 24'd0},
		{16'h4000, 1'b0, 24'd0},
		{16'hC000, 1'b0, 24'd0},
		{16'h8000, 1'b0, 24'd0}
	};

	logic                        clk      = 1'b0;
	logic                        arst_n   = 1'b0;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	logic [TDATA_W-1:0]          s_tdata  = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	logic [swrms_pkg::OUT_W-1:0] m_tdata;

	// Predictor state: its own copy of the window and of the sum of squares.
	logic signed [SAMPLE_BITS-1:0] window_copy [WINDOW];
	int unsigned                   window_pos = 0;
	logic [63:0]                   square_total = '0;

	logic [swrms_pkg::OUT_W-1:0] pending_levels [$];
	int                          fail_count = 0;
	int                          idle_cycles = 0;
	int                          tx_idle_pct = 0;
	int                          rx_idle_pct = 0;
	int                          hold_requests = 0;
	int                          hold_served = 0;
	int                          hold_left = 0;
	logic                        row_typed = 1'b0;
	logic [swrms_pkg::OUT_W-1:0] row_level = '0;

	sliding_window_rms_top #(
		.WINDOW     (WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		foreach (window_copy[i]) window_copy[i] = '0;
	end

	// Slide one sample into the window and return the RMS level that it should produce.
	function automatic logic [swrms_pkg::OUT_W-1:0] rms_predict(
			input logic [SAMPLE_BITS-1:0] raw);
		logic signed [SAMPLE_BITS-1:0] leaving;
		logic signed [63:0]            wide_old;
		logic signed [63:0]            wide_new;
		logic [63:0]                   mag_old;
		logic [63:0]                   mag_new;
		logic [63:0]                   quo;
		logic [63:0]                   rem;
		logic [63:0]                   rest;
		logic [63:0]                   root;
		logic [63:0]                   probe;
		leaving  = window_copy[window_pos];
		wide_old = leaving;
		wide_new = $signed(raw);
		mag_old  = (wide_old < 0) ? -wide_old : wide_old;
		mag_new  = (wide_new < 0) ? -wide_new : wide_new;
		square_total = square_total - mag_old * mag_old + mag_new * mag_new;
		window_copy[window_pos] = raw;
		window_pos = (window_pos + 1 >= WINDOW) ? 0 : window_pos + 1;

		// Exact floor of sum * 2^16 / WINDOW from quotient and remainder.
		quo  = square_total / 64'(WINDOW);
		rem  = square_total % 64'(WINDOW);
		rest = (quo << swrms_pkg::FRAC_BITS) + ((rem << swrms_pkg::FRAC_BITS) / 64'(WINDOW));

		// Floor square root, one result bit per pass.
		root  = '0;
		probe = 64'd1 << 62;
		while (probe > rest) probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		if (root > 64'(swrms_pkg::OUT_MAX))
			return swrms_pkg::OUT_MAX;
		return root[swrms_pkg::OUT_W-1:0];
	endfunction

	// Random audio content: full range most often, then quiet signal, very small values and extremes.
	function automatic logic [SAMPLE_BITS-1:0] random_sample();
		int kind;
		int v;
		kind = $urandom_range(9);
		case (kind)
			0, 1, 2, 3: begin
				return SAMPLE_BITS'($urandom);
			end
			4, 5, 6: begin
				v = $urandom_range(510);
				return SAMPLE_BITS'(v - 255);
			end
			7: begin
				v = $urandom_range(15);
				return SAMPLE_BITS'(v - 8);
			end
			default: begin
				case ($urandom_range(3))
					0: return MOST_NEGATIVE;
					1: return MOST_POSITIVE;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// Offer one sample request, idling first at random, and return at the next falling edge
	// after it was taken. Entered at a falling edge, so each edge sees one assignment.
	task automatic send_request(input logic [SAMPLE_BITS-1:0] smp, input logic typed,
			input logic [swrms_pkg::OUT_W-1:0] level);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid  <= 1'b1;
		s_tdata   <= TDATA_W'(smp);
		row_typed = typed;
		row_level = level;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	// Response side: random back-pressure, plus long hold-offs when asked.
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Compare each response with the oldest pending level, then record new requests.
	always @(posedge clk) begin : response_check
		logic [swrms_pkg::OUT_W-1:0] want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_levels.size() == 0) begin
					fail_count = fail_count + 1;
					if (fail_count <= REPORT_LIMIT)
						$display("unexpected rms_level %0d with no request pending", m_tdata);
				end else begin
					want = pending_levels.pop_front();
					if (m_tdata !== want) begin
						fail_count = fail_count + 1;
						if (fail_count <= REPORT_LIMIT)
							$display("rms_level mismatch: expected %0d, got %0d", want, m_tdata);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				want = rms_predict(s_tdata[SAMPLE_BITS-1:0]);
				pending_levels.push_back(row_typed ? row_level : want);
			end
		end
	end

	// Watchdog: too many cycles in a row without any handshake ends the run.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests, no idling.
		foreach (stim_rows[i])
			send_request(stim_rows[i].smp, stim_rows[i].typed, stim_rows[i].level);

		// Random requests with a receiver that often idles, then a sender that often idles.
		tx_idle_pct = 6;
		rx_idle_pct = 48;
		repeat (RANDOM_ITEMS) send_request(random_sample(), 1'b0, '0);
		tx_idle_pct = 48;
		rx_idle_pct = 6;
		repeat (RANDOM_ITEMS) send_request(random_sample(), 1'b0, '0);

		// Full speed: the receiver holds off at first while full-scale negative samples fill the
		// window; once it is full the level sits at its maximum.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_requests = hold_requests + 1;
		for (int n = 0; n < FILL_ITEMS; n++)
			send_request(MOST_NEGATIVE, n >= WINDOW - 1, FULL_SCALE_LEVEL);
		repeat (RANDOM_ITEMS) send_request(random_sample(), 1'b0, '0);
		s_tvalid <= 1'b0;

		// Drain the pending levels, then watch for stray responses.
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
